/* rtl/stgd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stgd_pkg: shared types and constants
// Field widths, command and register codes, and the bundles passed between
// the step logic and the top level of the switch toggle gesture detector.
// ----------------------------------------------------------------------------
package stgd_pkg;

    localparam int TIME_BITS  = 48;
    localparam int POS_BITS   = 8;
    localparam int TALLY_BITS = 8;
    localparam int WIN_BITS   = 32;
    localparam int CFG_BITS   = 32;
    localparam int IDX_BITS   = 2;

    localparam logic [TALLY_BITS-1:0] TALLY_MAX       = '1;
    localparam logic [TALLY_BITS-1:0] RST_TO_TRIGGER  = 8'd6;
    localparam logic [TALLY_BITS-1:0] RST_TO_EXIT     = 8'd10;
    localparam logic                  RST_EXIT_ENABLE = 1'b1;
    localparam logic [WIN_BITS-1:0]   RST_WINDOW_US   = 32'd1000000;

    typedef enum logic [1:0] {
        CMD_SAMPLE    = 2'd0,
        CMD_LINK_LOST = 2'd1,
        CMD_ARMED_RPT = 2'd2
    } cmd_t;

    typedef enum logic [IDX_BITS-1:0] {
        REG_TO_TRIGGER  = 2'd0,
        REG_TO_EXIT     = 2'd1,
        REG_EXIT_ENABLE = 2'd2,
        REG_WINDOW_US   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [TALLY_BITS-1:0] toggles_to_trigger;
        logic [TALLY_BITS-1:0] toggles_to_exit;
        logic                  exit_enable;
        logic [WIN_BITS-1:0]   window_us;
    } cfg_t;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [POS_BITS-1:0]  switch_pos;
        logic [TIME_BITS-1:0] now_us;
        logic                 armed_flag;
    } item_t;

    typedef struct packed {
        logic [POS_BITS-1:0]   prev_pos;
        logic                  prev_known;
        logic [TALLY_BITS-1:0] toggle_tally;
        logic [TIME_BITS-1:0]  last_change_time;
        logic                  is_armed;
        logic                  stopped;
    } state_t;

    typedef struct packed {
        logic                  trigger;
        logic                  exit_request;
        logic [TALLY_BITS-1:0] count_now;
        logic                  halted;
    } result_t;

endpackage : stgd_pkg
`default_nettype wire

/* rtl/stgd_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stgd_step: per-request update logic
// Takes the current detector state and one request, and produces the next
// state and the result for that request. Purely combinational.
// ----------------------------------------------------------------------------
module stgd_step (
    input  wire stgd_pkg::cfg_t    cfg_i,
    input  wire stgd_pkg::state_t  state_i,
    input  wire stgd_pkg::item_t   item_i,
    output stgd_pkg::state_t       state_next_o,
    output stgd_pkg::result_t      result_o
);
    import stgd_pkg::*;

    state_t               st;
    logic                 trig;
    logic                 ex;
    logic                 changed;
    logic [TIME_BITS-1:0] gap;

    always_comb begin
        st      = state_i;
        trig    = 1'b0;
        ex      = 1'b0;
        changed = 1'b0;
        gap     = '0;
        if (!st.stopped) begin
            case (item_i.cmd)
                CMD_ARMED_RPT: begin
                    if (item_i.armed_flag) begin
                        st.prev_known       = 1'b0;
                        st.toggle_tally     = '0;
                        st.last_change_time = '0;
                    end
                    st.is_armed = item_i.armed_flag;
                end
                CMD_LINK_LOST: begin
                    if (!st.is_armed) begin
                        st.prev_known       = 1'b0;
                        st.toggle_tally     = '0;
                        st.last_change_time = '0;
                    end
                end
                CMD_SAMPLE: begin
                    if (!st.is_armed) begin
                        if (!st.prev_known) begin
                            // first sample after a clear only records the position
                            st.prev_pos   = item_i.switch_pos;
                            st.prev_known = 1'b1;
                        end else if (item_i.switch_pos != st.prev_pos) begin
                            if (st.last_change_time == '0) begin
                                st.last_change_time = item_i.now_us;
                                st.toggle_tally     = TALLY_BITS'(1);
                            end else if (st.toggle_tally != TALLY_MAX) begin
                                st.toggle_tally = st.toggle_tally + TALLY_BITS'(1);
                            end
                            st.prev_pos = item_i.switch_pos;
                            changed     = 1'b1;
                        end
                        gap = item_i.now_us - st.last_change_time;
                        if (gap > {{(TIME_BITS-WIN_BITS){1'b0}}, cfg_i.window_us}) begin
                            // burst over: judge the tally
                            if (st.toggle_tally != '0 &&
                                st.toggle_tally >= cfg_i.toggles_to_trigger) begin
                                if (cfg_i.exit_enable &&
                                    st.toggle_tally >= cfg_i.toggles_to_exit) begin
                                    st.prev_known       = 1'b0;
                                    st.toggle_tally     = '0;
                                    st.last_change_time = '0;
                                    st.stopped          = 1'b1;
                                    ex                  = 1'b1;
                                end else begin
                                    trig = 1'b1;
                                end
                            end
                            if (!st.stopped) begin
                                st.toggle_tally     = '0;
                                st.prev_pos         = item_i.switch_pos;
                                st.prev_known       = 1'b1;
                                st.last_change_time = '0;
                            end
                        end else if (changed) begin
                            st.last_change_time = item_i.now_us;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        state_next_o          = st;
        result_o.trigger      = trig;
        result_o.exit_request = ex;
        result_o.count_now    = st.stopped ? '0 : st.toggle_tally;
        result_o.halted       = st.stopped;
    end

endmodule : stgd_step
`default_nettype wire

/* rtl/switch_toggle_gesture_detector.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// switch_toggle_gesture_detector: switch toggle burst detector
// Counts position changes of a remote-control switch and judges each burst.
//
// Input channel (s_*): one request per switch sample, link timeout or armed
// report. Result channel (m_*): exactly one result per request, in order.
// Configuration: cfg_wr_en/cfg_index/cfg_wr_data write one register per
// cycle; write only while no request is in flight.
//
// Pipeline: a request is held in the input register, then the step logic
// updates the detector state and loads the result register, which drives
// m_valid. Throughput: one request per cycle while m_ready stays high, set
// by the single state update in the step logic.
// When the receiver stalls, the result register holds and the input
// register takes one more request; s_ready then drops until m_ready returns.
// Reset (aresetn low, synchronous): registers go to their defaults, the
// detector comes up armed with no known position, and both channels empty.
// ----------------------------------------------------------------------------
module switch_toggle_gesture_detector (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire  [1:0]                      s_cmd,
    input  wire  [stgd_pkg::POS_BITS-1:0]   s_switch_pos,
    input  wire  [stgd_pkg::TIME_BITS-1:0]  s_now_us,
    input  wire                             s_armed_flag,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic                            m_trigger,
    output logic                            m_exit_request,
    output logic [stgd_pkg::TALLY_BITS-1:0] m_count_now,
    output logic                            m_halted,
    input  wire                             cfg_wr_en,
    input  wire  [stgd_pkg::IDX_BITS-1:0]   cfg_index,
    input  wire  [stgd_pkg::CFG_BITS-1:0]   cfg_wr_data
);
    import stgd_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t step_result;
    logic    out_valid_reg;
    result_t out_reg;
    logic    advance;

    // move the held request through the step logic when the result slot frees
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.toggles_to_trigger <= RST_TO_TRIGGER;
            cfg_reg.toggles_to_exit    <= RST_TO_EXIT;
            cfg_reg.exit_enable        <= RST_EXIT_ENABLE;
            cfg_reg.window_us          <= RST_WINDOW_US;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TO_TRIGGER:  cfg_reg.toggles_to_trigger <= cfg_wr_data[TALLY_BITS-1:0];
                REG_TO_EXIT:     cfg_reg.toggles_to_exit    <= cfg_wr_data[TALLY_BITS-1:0];
                REG_EXIT_ENABLE: cfg_reg.exit_enable        <= cfg_wr_data[0];
                REG_WINDOW_US:   cfg_reg.window_us          <= cfg_wr_data[WIN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg.cmd        <= s_cmd;
            in_item_reg.switch_pos <= s_switch_pos;
            in_item_reg.now_us     <= s_now_us;
            in_item_reg.armed_flag <= s_armed_flag;
        end
    end

    stgd_step u_step (
        .cfg_i        (cfg_reg),
        .state_i      (state_reg),
        .item_i       (in_item_reg),
        .state_next_o (state_next),
        .result_o     (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.prev_pos         <= '0;
            state_reg.prev_known       <= 1'b0;
            state_reg.toggle_tally     <= '0;
            state_reg.last_change_time <= '0;
            state_reg.is_armed         <= 1'b1;
            state_reg.stopped          <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_trigger      = out_reg.trigger;
    assign m_exit_request = out_reg.exit_request;
    assign m_count_now    = out_reg.count_now;
    assign m_halted       = out_reg.halted;

endmodule : switch_toggle_gesture_detector
`default_nettype wire
